@@ hdl/sha256_sha224_hasher_defines.svh @@
// Assertion helpers used by the asserting file, sha256_sha224_hasher.sv.
`ifndef SHA256_SHA224_HASHER_DEFINES_SVH
`define SHA256_SHA224_HASHER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SHA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/sha_pkg.sv @@
package sha_pkg;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;
   localparam logic [5:0] FILL_TOP = 6'd63;
   localparam logic [2:0] LAST_IDX_256 = 3'd7;
   localparam logic [2:0] LAST_IDX_224 = 3'd6;
   localparam logic [3:0] LEN_HI_ADDR = 4'd14;
   localparam logic [3:0] LEN_LO_ADDR = 4'd15;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
      32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
      32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
      32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
      32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
      32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
      32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
      32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
      32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
      32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
      32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
      32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
      32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
      32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
      32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
   };

   // Initial vectors, SHA-256 in entries 0 to 7 and SHA-224 in entries 8 to 15.
   localparam logic [31:0] INIT_VEC [16] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19,
      32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
      32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4
   };

   typedef enum logic [3:0] {
      T_INIT, T_IDLE, T_BYTE, T_PAD, T_ZERO, T_LEN_HI, T_LEN_LO,
      T_COMP, T_OUT_RD, T_OUT_SHOW
   } top_state_type;

   typedef enum logic [2:0] {
      C_IDLE, C_INIT, C_LOAD, C_ROUND, C_FOLD
   } core_state_type;

   typedef struct packed {
      logic init;
      logic compress;
      logic mode;
   } core_cmd_type;

   typedef struct packed {
      logic busy;
      logic folding;
   } core_stat_type;

endpackage

@@ hdl/sha_buf.sv @@
module sha_buf (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [3:0]  wr_addr,
   input  logic [3:0]  wr_be,
   input  logic [31:0] wr_data,
   input  logic [3:0]  rd_addr,
   output logic [31:0] rd_data
);

   logic [31:0] mem [16];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int b = 0; b < 4; b++) begin
            if (wr_be[b]) begin
               mem[wr_addr][8*b +: 8] <= wr_data[8*b +: 8];
            end
         end
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/sha_core.sv @@
module sha_core (
   input  logic                  clock,
   input  logic                  reset,
   input  sha_pkg::core_cmd_type cmd,
   input  logic [2:0]            ext_raddr,
   output logic [3:0]            buf_raddr,
   input  logic [31:0]           buf_rdata,
   output logic [31:0]           hash_rdata,
   output sha_pkg::core_stat_type stat
);

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   sha_pkg::core_state_type state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic        mode_ff;
   logic [31:0] v_ff [8];
   logic [31:0] w_ff [16];
   logic [31:0] hash_mem [8];
   logic [31:0] hash_rdata_ff;

   logic [2:0]  hash_raddr;
   logic        hash_we;
   logic [2:0]  hash_waddr;
   logic [31:0] hash_wdata;
   logic [2:0]  prev_idx;

   logic [31:0] w_cur, s0, s1, t1, t2;

   assign prev_idx = cnt_ff[2:0] - 3'd1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      if (cmd.init) begin
         state_in = sha_pkg::C_INIT;
      end else begin
         unique case (state_ff)
            sha_pkg::C_IDLE:  if (cmd.compress) state_in = sha_pkg::C_LOAD;
            sha_pkg::C_INIT:  if (cnt_ff == 4'd7) state_in = sha_pkg::C_IDLE;
            sha_pkg::C_LOAD:  if (cnt_ff == 4'd8) state_in = sha_pkg::C_ROUND;
            sha_pkg::C_ROUND: if (rnd_ff == 6'd63) state_in = sha_pkg::C_FOLD;
            sha_pkg::C_FOLD:  if (cnt_ff == 4'd8) state_in = sha_pkg::C_IDLE;
            default:          state_in = sha_pkg::C_IDLE;
         endcase
      end
      cnt_in = (cmd.init || state_in != state_ff) ? 4'd0 : cnt_ff + 4'd1;
      rnd_in = (state_ff == sha_pkg::C_ROUND) ? rnd_ff + 6'd1 : 6'd0;
   end

   // Memory port control.
   always_comb begin
      hash_raddr = ext_raddr;
      hash_we    = 1'b0;
      hash_waddr = cnt_ff[2:0];
      hash_wdata = sha_pkg::INIT_VEC[{mode_ff, cnt_ff[2:0]}];
      buf_raddr  = 4'd0;
      unique case (state_ff)
         sha_pkg::C_IDLE: ;
         sha_pkg::C_INIT: hash_we = 1'b1;
         sha_pkg::C_LOAD: hash_raddr = cnt_ff[2:0];
         sha_pkg::C_ROUND: buf_raddr = rnd_ff[3:0] + 4'd1;
         sha_pkg::C_FOLD: begin
            hash_raddr = cnt_ff[2:0];
            hash_we    = (cnt_ff != 4'd0);
            hash_waddr = prev_idx;
            hash_wdata = hash_rdata_ff + v_ff[prev_idx];
         end
         default: ;
      endcase
   end

   // One round of the compression.
   always_comb begin
      s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_cur = (rnd_ff < 6'd16) ? buf_rdata : w_ff[0] + s0 + w_ff[9] + s1;
      t1 = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + sha_pkg::ROUND_K[rnd_ff] + w_cur;
      t2 = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha_pkg::C_INIT;
         cnt_ff   <= 4'd0;
         rnd_ff   <= 6'd0;
         mode_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rnd_ff   <= rnd_in;
         if (cmd.init) begin
            mode_ff <= cmd.mode;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hash_we) begin
         hash_mem[hash_waddr] <= hash_wdata;
      end
      hash_rdata_ff <= hash_mem[hash_raddr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == sha_pkg::C_LOAD && cnt_ff != 4'd0) begin
         v_ff[prev_idx] <= hash_rdata_ff;
      end else if (state_ff == sha_pkg::C_ROUND) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
      if (state_ff == sha_pkg::C_ROUND) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[15] <= w_cur;
      end
   end

   assign hash_rdata   = hash_rdata_ff;
   assign stat.busy    = (state_ff != sha_pkg::C_IDLE);
   assign stat.folding = (state_ff == sha_pkg::C_FOLD);

endmodule

@@ hdl/sha256_sha224_hasher.sv @@
//  Channel   Direction  Handshake            Payload
//  req_      in         req_valid/req_ready  data_word, valid_bytes, end_of_message
//  rsp_      out        rsp_valid/rsp_ready  digest_word, word_index, status, last_word
//  csr_      in         csr_wr_en            digest_mode (csr_wr_data)
//
//  An item is taken in T_IDLE; T_BYTE writes its valid bytes at one byte a cycle, except
//  during a block compression, then finishes. A full block holds the input while the core
//  loads, runs its rounds and folds, until T_COMP resumes. The final item adds padding, also
//  at one byte a cycle outside compressions, one or two compressions and each digest word
//  read out of the hash memory. Reset is synchronous and active high; the initial vector then
//  loads before req_ready rises, as after a configuration write or the last digest word.
`include "sha256_sha224_hasher_defines.svh"

module sha256_sha224_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_status,
   output logic        rsp_last_word,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   sha_pkg::top_state_type state_ff, state_in, ret_ff, ret_in;
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] len_ff, len_in;
   logic        ovf_ff, ovf_in;
   logic        mode_ff;
   logic [31:0] data_ff, data_in;
   logic [2:0]  left_ff, left_in;
   logic        eom_ff, eom_in;
   logic [2:0]  idx_ff, idx_in;

   logic        req_xfer, rsp_xfer, last_idx;
   logic [2:0]  n_clamp;
   logic [61:0] len_sum;

   sha_pkg::core_cmd_type  cmd;
   sha_pkg::core_stat_type core_stat;
   logic [3:0]  buf_raddr;
   logic [31:0] buf_rdata;
   logic [31:0] hash_rdata;
   logic        buf_we;
   logic [3:0]  buf_waddr, buf_be;
   logic [31:0] buf_wdata;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;
   assign last_idx = (idx_ff == (mode_ff ? sha_pkg::LAST_IDX_224 : sha_pkg::LAST_IDX_256));
   assign n_clamp  = (req_valid_bytes > 3'd4) ? 3'd4 : req_valid_bytes;
   assign len_sum  = {1'b0, len_ff} + {59'd0, n_clamp};

   // Next state.
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      priority if (csr_wr_en) begin
         state_in = sha_pkg::T_INIT;
      end else begin
         unique case (state_ff)
            sha_pkg::T_INIT: if (!core_stat.busy) state_in = sha_pkg::T_IDLE;
            sha_pkg::T_IDLE: if (req_xfer) state_in = sha_pkg::T_BYTE;
            sha_pkg::T_BYTE: begin
               if (left_ff != 3'd0) begin
                  if (fill_ff == sha_pkg::FILL_TOP) begin
                     state_in = sha_pkg::T_COMP;
                     ret_in   = sha_pkg::T_BYTE;
                  end
               end else begin
                  state_in = eom_ff ? sha_pkg::T_PAD : sha_pkg::T_IDLE;
               end
            end
            sha_pkg::T_PAD: begin
               state_in = sha_pkg::T_ZERO;
               if (fill_ff == sha_pkg::FILL_TOP) begin
                  state_in = sha_pkg::T_COMP;
                  ret_in   = sha_pkg::T_ZERO;
               end
            end
            sha_pkg::T_ZERO: begin
               if (fill_ff == sha_pkg::LEN_POS) begin
                  state_in = sha_pkg::T_LEN_HI;
               end else if (fill_ff == sha_pkg::FILL_TOP) begin
                  state_in = sha_pkg::T_COMP;
                  ret_in   = sha_pkg::T_ZERO;
               end
            end
            sha_pkg::T_LEN_HI: state_in = sha_pkg::T_LEN_LO;
            sha_pkg::T_LEN_LO: begin
               state_in = sha_pkg::T_COMP;
               ret_in   = sha_pkg::T_OUT_RD;
            end
            sha_pkg::T_COMP: if (!core_stat.busy) state_in = ret_ff;
            sha_pkg::T_OUT_RD: state_in = sha_pkg::T_OUT_SHOW;
            sha_pkg::T_OUT_SHOW: begin
               if (rsp_xfer) begin
                  state_in = last_idx ? sha_pkg::T_INIT : sha_pkg::T_OUT_RD;
               end
            end
            default: state_in = sha_pkg::T_INIT;
         endcase
      end
   end

   // Outputs and datapath next values.
   always_comb begin
      req_ready    = (state_ff == sha_pkg::T_IDLE);
      rsp_valid    = (state_ff == sha_pkg::T_OUT_SHOW);
      cmd.init     = csr_wr_en || (rsp_xfer && last_idx);
      cmd.compress = (state_in == sha_pkg::T_COMP) && (state_ff != sha_pkg::T_COMP);
      cmd.mode     = csr_wr_en ? csr_wr_data : mode_ff;
      buf_we       = 1'b0;
      buf_waddr    = fill_ff[5:2];
      buf_be       = 4'b1000 >> fill_ff[1:0];
      buf_wdata    = {4{8'h00}};
      fill_in      = fill_ff;
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      data_in      = data_ff;
      left_in      = left_ff;
      eom_in       = eom_ff;
      idx_in       = idx_ff;
      unique case (state_ff)
         sha_pkg::T_IDLE: begin
            if (req_xfer) begin
               data_in = req_data_word;
               eom_in  = req_end_of_message;
               idx_in  = 3'd0;
               // A transfer that would push the length past its limit is dropped.
               if (len_sum[61]) begin
                  ovf_in  = 1'b1;
                  left_in = 3'd0;
               end else begin
                  left_in = n_clamp;
               end
            end
         end
         sha_pkg::T_BYTE: begin
            if (left_ff != 3'd0) begin
               buf_we    = 1'b1;
               buf_wdata = {4{data_ff[31:24]}};
               fill_in   = fill_ff + 6'd1;
               data_in   = {data_ff[23:0], 8'h00};
               left_in   = left_ff - 3'd1;
               len_in    = len_ff + 61'd1;
            end
         end
         sha_pkg::T_PAD: begin
            buf_we    = 1'b1;
            buf_wdata = {4{sha_pkg::PAD_BYTE}};
            fill_in   = fill_ff + 6'd1;
         end
         sha_pkg::T_ZERO: begin
            if (fill_ff != sha_pkg::LEN_POS) begin
               buf_we  = 1'b1;
               fill_in = fill_ff + 6'd1;
            end
         end
         sha_pkg::T_LEN_HI: begin
            buf_we    = 1'b1;
            buf_waddr = sha_pkg::LEN_HI_ADDR;
            buf_be    = 4'b1111;
            buf_wdata = len_ff[60:29];
         end
         sha_pkg::T_LEN_LO: begin
            buf_we    = 1'b1;
            buf_waddr = sha_pkg::LEN_LO_ADDR;
            buf_be    = 4'b1111;
            buf_wdata = {len_ff[28:0], 3'b000};
            fill_in   = 6'd0;
         end
         sha_pkg::T_OUT_SHOW: begin
            if (rsp_xfer) begin
               idx_in = idx_ff + 3'd1;
               if (last_idx) begin
                  fill_in = 6'd0;
                  len_in  = 61'd0;
               end
            end
         end
         sha_pkg::T_INIT, sha_pkg::T_COMP, sha_pkg::T_OUT_RD: ;
         default: ;
      endcase
      // A configuration write restarts the message.
      if (csr_wr_en) begin
         fill_in = 6'd0;
         len_in  = 61'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha_pkg::T_INIT;
         ret_ff   <= sha_pkg::T_IDLE;
         fill_ff  <= 6'd0;
         len_ff   <= 61'd0;
         ovf_ff   <= 1'b0;
         mode_ff  <= 1'b0;
         left_ff  <= 3'd0;
         eom_ff   <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         fill_ff  <= fill_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
         left_ff  <= left_in;
         eom_ff   <= eom_in;
         idx_ff   <= idx_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   sha_buf u_buf (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_waddr),
      .wr_be   (buf_be),
      .wr_data (buf_wdata),
      .rd_addr (buf_raddr),
      .rd_data (buf_rdata)
   );

   sha_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .ext_raddr  (idx_ff),
      .buf_raddr  (buf_raddr),
      .buf_rdata  (buf_rdata),
      .hash_rdata (hash_rdata),
      .stat       (core_stat)
   );

   // The hash memory read register is the output register of the result channel.
   assign rsp_digest_word = hash_rdata;
   assign rsp_word_index  = idx_ff;
   assign rsp_status      = ovf_ff;
   assign rsp_last_word   = last_idx;

   `SHA_ASSERT_NOW(a_rsp_core_quiet, rsp_valid, !core_stat.busy, "digest shown while core busy")
   `SHA_ASSERT_NOW(a_len_pos, state_ff == sha_pkg::T_LEN_HI, fill_ff == sha_pkg::LEN_POS, "length written at wrong fill")
   `SHA_ASSERT_NEXT(a_ovf_sticky, ovf_ff, ovf_ff, "overflow flag cleared")
   `SHA_ASSERT_NOW(a_last_idx, rsp_valid && rsp_last_word, rsp_word_index == 3'd6 || rsp_word_index == 3'd7, "last word at wrong index")
   `SHA_ASSERT_NOW(a_fold_no_buf_write, core_stat.folding, !buf_we, "block buffer written during fold")

endmodule
